// ----- sv/dtb_pkg.sv -----
package dtb_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  localparam int PRICE_W = 31;
  localparam int GAIN_W  = 16;
  localparam int DAYS_W  = 7;
  localparam int LEVEL_W = 34;
  localparam int FRAC_W  = 12;
  localparam int RANGE_W = PRICE_W + 1;
  localparam int Q_W     = RANGE_W + GAIN_W + 1;
  localparam int ROUND_W = Q_W - FRAC_W;
  localparam int ENTRY_W = 3 * PRICE_W;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

  localparam logic [DAYS_W-1:0] WINDOW_DAYS_RST = DAYS_W'(4);
  localparam logic [GAIN_W-1:0] UPPER_GAIN_RST  = GAIN_W'(2867);
  localparam logic [GAIN_W-1:0] LOWER_GAIN_RST  = GAIN_W'(2867);

  typedef enum logic [1:0] {
    REG_WINDOW_DAYS = 2'd0,
    REG_UPPER_GAIN  = 2'd1,
    REG_LOWER_GAIN  = 2'd2,
    REG_NONE        = 2'd3
  } dtb_reg_t;

  localparam logic signed [1:0] POS_SHORT = -2'sd1;
  localparam logic signed [1:0] POS_FLAT  = 2'sd0;
  localparam logic signed [1:0] POS_LONG  = 2'sd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RANGE,
    ST_MUL_UP,
    ST_MUL_LO,
    ST_SUM_LO,
    ST_DECIDE
  } dtb_state_t;

  function automatic logic signed [LEVEL_W-1:0] level_out(input logic signed [Q_W-1:0] q);
    logic signed [Q_W-1:0]     qr;
    logic signed [ROUND_W-1:0] v;
    logic signed [LEVEL_W-1:0] res;
    qr = q + Q_W'(1 << (FRAC_W - 1));
    v  = qr[Q_W-1:FRAC_W];
    if (v[ROUND_W-1:LEVEL_W-1] == {(ROUND_W-LEVEL_W+1){1'b0}} ||
        v[ROUND_W-1:LEVEL_W-1] == {(ROUND_W-LEVEL_W+1){1'b1}}) begin
      res = v[LEVEL_W-1:0];
    end else if (v[ROUND_W-1]) begin
      res = {1'b1, {(LEVEL_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(LEVEL_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ----- sv/dtb_bar_if.sv -----
interface dtb_bar_if;
  logic                         valid;
  logic                         ready;
  logic [dtb_pkg::PRICE_W-1:0] bar_open;
  logic [dtb_pkg::PRICE_W-1:0] bar_high;
  logic [dtb_pkg::PRICE_W-1:0] bar_low;
  logic [dtb_pkg::PRICE_W-1:0] bar_close;
  logic                         bar_closed;

  modport source (output valid, bar_open, bar_high, bar_low, bar_close, bar_closed,
                  input ready);
  modport sink (input valid, bar_open, bar_high, bar_low, bar_close, bar_closed,
                output ready);
endinterface

// ----- sv/dtb_sig_if.sv -----
interface dtb_sig_if;
  logic                                valid;
  logic                                ready;
  logic signed [1:0]                   position;
  logic signed [dtb_pkg::LEVEL_W-1:0] upper_level;
  logic signed [dtb_pkg::LEVEL_W-1:0] lower_level;

  modport source (output valid, position, upper_level, lower_level, input ready);
  modport sink (input valid, position, upper_level, lower_level, output ready);
endinterface

// ----- sv/dual_thrust_breakout_signal.sv -----
// channel   dir  words                                          handshake
// bar_in    in   bar_open, bar_high, bar_low, bar_close, closed valid/ready
// sig_out   out  position, upper_level, lower_level             valid/ready
// apb       in   window_days @0x0, upper_gain @0x4, lower_gain @0x8
//
// a bar runs IDLE, SCAN over min(window_days, stored bars) bars, DRAIN, RANGE, MUL_UP,
// MUL_LO, SUM_LO, DECIDE (empty window: IDLE to MUL_UP); the scan reads one stored bar
// a cycle via the window ram's single read port; the bound products share one multiplier
// rst is synchronous; the window ram is not cleared, a fill count limits reads
// a finished word waits in the output register while the next bar is taken;
// the decide step holds until that register is free
module dual_thrust_breakout_signal (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dtb_pkg::APB_AW-1:0]  paddr,
  input  logic [dtb_pkg::APB_DW-1:0]  pwdata,
  output logic [dtb_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  dtb_bar_if.sink                      bar_in,
  dtb_sig_if.source                    sig_out
);

  // configuration
  logic [dtb_pkg::DAYS_W-1:0] window_days;
  logic [dtb_pkg::GAIN_W-1:0] upper_gain;
  logic [dtb_pkg::GAIN_W-1:0] lower_gain;
  dtb_pkg::dtb_reg_t          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = dtb_pkg::dtb_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_days <= dtb_pkg::WINDOW_DAYS_RST;
      upper_gain  <= dtb_pkg::UPPER_GAIN_RST;
      lower_gain  <= dtb_pkg::LOWER_GAIN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        dtb_pkg::REG_WINDOW_DAYS: window_days <= pwdata[dtb_pkg::DAYS_W-1:0];
        dtb_pkg::REG_UPPER_GAIN:  upper_gain  <= pwdata[dtb_pkg::GAIN_W-1:0];
        dtb_pkg::REG_LOWER_GAIN:  lower_gain  <= pwdata[dtb_pkg::GAIN_W-1:0];
        dtb_pkg::REG_NONE: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dtb_pkg::REG_WINDOW_DAYS: prdata = dtb_pkg::APB_DW'(window_days);
      dtb_pkg::REG_UPPER_GAIN:  prdata = dtb_pkg::APB_DW'(upper_gain);
      dtb_pkg::REG_LOWER_GAIN:  prdata = dtb_pkg::APB_DW'(lower_gain);
      dtb_pkg::REG_NONE:        prdata = '0;
    endcase
  end

  // sequencer
  dtb_pkg::dtb_state_t state, state_next;

  logic [dtb_pkg::PRICE_W-1:0] open_r, high_r, low_r, close_r;
  logic                        closed_r;
  logic [dtb_pkg::SLOT_W-1:0]  write_slot;
  logic [dtb_pkg::CNT_W-1:0]   stored_count;
  logic signed [1:0]           held_position;
  logic [dtb_pkg::SLOT_W-1:0]  rd_slot;
  logic [dtb_pkg::CNT_W-1:0]   remaining;
  logic                        rd_pend;
  logic [dtb_pkg::PRICE_W-1:0] hh, hc, lc, ll;
  logic signed [dtb_pkg::RANGE_W-1:0] range_r;
  logic signed [dtb_pkg::Q_W-1:0]     prod, upper_q, lower_q;

  logic                        accept, advance;
  logic [dtb_pkg::CNT_W-1:0]   days_clip, span;
  logic                        ram_we;
  logic [dtb_pkg::ENTRY_W-1:0] ram_rdata;
  logic [dtb_pkg::PRICE_W-1:0] rd_high, rd_low, rd_close;

  assign accept  = bar_in.valid && bar_in.ready;
  assign advance = (state == dtb_pkg::ST_DECIDE) && (!sig_out.valid || sig_out.ready);

  assign rd_high  = ram_rdata[3*dtb_pkg::PRICE_W-1:2*dtb_pkg::PRICE_W];
  assign rd_low   = ram_rdata[2*dtb_pkg::PRICE_W-1:dtb_pkg::PRICE_W];
  assign rd_close = ram_rdata[dtb_pkg::PRICE_W-1:0];

  function automatic logic [dtb_pkg::SLOT_W-1:0] prev_slot(input logic [dtb_pkg::SLOT_W-1:0] s);
    return (s == '0) ? dtb_pkg::SLOT_W'(dtb_pkg::MAX_WINDOW - 1) : s - 1'b1;
  endfunction

  always_comb begin
    if (32'(window_days) > 32'(dtb_pkg::MAX_WINDOW)) begin
      days_clip = dtb_pkg::CNT_W'(dtb_pkg::MAX_WINDOW);
    end else begin
      days_clip = dtb_pkg::CNT_W'(window_days);
    end
    span = (days_clip > stored_count) ? stored_count : days_clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    bar_in.ready = 1'b0;
    ram_we       = 1'b0;
    unique case (state)
      dtb_pkg::ST_IDLE: begin
        bar_in.ready = 1'b1;
        if (bar_in.valid) begin
          state_next = (span == '0) ? dtb_pkg::ST_MUL_UP : dtb_pkg::ST_SCAN;
        end
      end
      dtb_pkg::ST_SCAN: begin
        if (remaining == dtb_pkg::CNT_W'(1)) begin
          state_next = dtb_pkg::ST_DRAIN;
        end
      end
      dtb_pkg::ST_DRAIN:  state_next = dtb_pkg::ST_RANGE;
      dtb_pkg::ST_RANGE:  state_next = dtb_pkg::ST_MUL_UP;
      dtb_pkg::ST_MUL_UP: state_next = dtb_pkg::ST_MUL_LO;
      dtb_pkg::ST_MUL_LO: state_next = dtb_pkg::ST_SUM_LO;
      dtb_pkg::ST_SUM_LO: state_next = dtb_pkg::ST_DECIDE;
      dtb_pkg::ST_DECIDE: begin
        if (advance) begin
          ram_we     = closed_r;
          state_next = dtb_pkg::ST_IDLE;
        end
      end
      default: state_next = dtb_pkg::ST_IDLE;
    endcase
  end

  dtb_ram #(
    .WIDTH (dtb_pkg::ENTRY_W),
    .DEPTH (dtb_pkg::MAX_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata ({high_r, low_r, close_r}),
    .raddr (rd_slot),
    .rdata (ram_rdata)
  );

  // datapath
  logic signed [dtb_pkg::RANGE_W-1:0] d1, d2;
  logic signed [dtb_pkg::GAIN_W:0]    gain_s;
  logic signed [dtb_pkg::Q_W-1:0]     open_q, high_q, low_q;
  logic                               up_hit, down_hit;
  logic signed [1:0]                  pos_next;

  assign d1 = $signed({1'b0, hh}) - $signed({1'b0, lc});
  assign d2 = $signed({1'b0, hc}) - $signed({1'b0, ll});
  assign gain_s = (state == dtb_pkg::ST_MUL_UP) ? $signed({1'b0, upper_gain})
                                                : $signed({1'b0, lower_gain});
  assign open_q = $signed({{(dtb_pkg::Q_W-dtb_pkg::PRICE_W-dtb_pkg::FRAC_W){1'b0}},
                           open_r, {dtb_pkg::FRAC_W{1'b0}}});
  assign high_q = $signed({{(dtb_pkg::Q_W-dtb_pkg::PRICE_W-dtb_pkg::FRAC_W){1'b0}},
                           high_r, {dtb_pkg::FRAC_W{1'b0}}});
  assign low_q  = $signed({{(dtb_pkg::Q_W-dtb_pkg::PRICE_W-dtb_pkg::FRAC_W){1'b0}},
                           low_r, {dtb_pkg::FRAC_W{1'b0}}});
  assign up_hit   = high_q >= upper_q;
  assign down_hit = low_q <= lower_q;

  always_comb begin
    pos_next = held_position;
    priority if (held_position == dtb_pkg::POS_FLAT) begin
      if (down_hit) begin
        pos_next = dtb_pkg::POS_SHORT;
      end else if (up_hit) begin
        pos_next = dtb_pkg::POS_LONG;
      end
    end else if (held_position == dtb_pkg::POS_LONG) begin
      if (down_hit) begin
        pos_next = dtb_pkg::POS_FLAT;
      end
    end else begin
      if (up_hit) begin
        pos_next = dtb_pkg::POS_FLAT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot    <= '0;
      stored_count  <= '0;
      held_position <= dtb_pkg::POS_FLAT;
      rd_pend       <= 1'b0;
      sig_out.valid <= 1'b0;
    end else begin
      rd_pend <= (state == dtb_pkg::ST_SCAN);
      if (advance) begin
        held_position <= pos_next;
        sig_out.valid <= 1'b1;
        if (closed_r) begin
          write_slot <= (write_slot == dtb_pkg::SLOT_W'(dtb_pkg::MAX_WINDOW - 1)) ?
                        '0 : write_slot + 1'b1;
          if (stored_count < dtb_pkg::CNT_W'(dtb_pkg::MAX_WINDOW)) begin
            stored_count <= stored_count + 1'b1;
          end
        end
      end else if (sig_out.ready) begin
        sig_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      open_r    <= bar_in.bar_open;
      high_r    <= bar_in.bar_high;
      low_r     <= bar_in.bar_low;
      close_r   <= bar_in.bar_close;
      closed_r  <= bar_in.bar_closed;
      rd_slot   <= prev_slot(write_slot);
      remaining <= span;
      range_r   <= '0;
      hh        <= '0;
      hc        <= '0;
      lc        <= dtb_pkg::PRICE_MAX;
      ll        <= dtb_pkg::PRICE_MAX;
    end else begin
      if (state == dtb_pkg::ST_SCAN) begin
        rd_slot   <= prev_slot(rd_slot);
        remaining <= remaining - 1'b1;
      end
      if (rd_pend) begin
        if (rd_high > hh) hh <= rd_high;
        if (rd_close > hc) hc <= rd_close;
        if (rd_close < lc) lc <= rd_close;
        if (rd_low < ll) ll <= rd_low;
      end
    end
    unique case (state)
      dtb_pkg::ST_RANGE: range_r <= (d1 > d2) ? d1 : d2;
      dtb_pkg::ST_MUL_UP: prod <= range_r * gain_s;
      dtb_pkg::ST_MUL_LO: begin
        upper_q <= open_q + prod;
        prod    <= range_r * gain_s;
      end
      dtb_pkg::ST_SUM_LO: lower_q <= open_q - prod;
      default: ;
    endcase
    if (advance) begin
      sig_out.position    <= pos_next;
      sig_out.upper_level <= dtb_pkg::level_out(upper_q);
      sig_out.lower_level <= dtb_pkg::level_out(lower_q);
    end
  end

endmodule

// ----- sv/dtb_ram.sv -----
module dtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
